[src/low_pulse_occupancy_meter_assert.svh]
// assertion macros for the occupancy meter
`ifndef LOW_PULSE_OCCUPANCY_METER_ASSERT_SVH
`define LOW_PULSE_OCCUPANCY_METER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LPOM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define LPOM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/lpom_pkg.sv]
// ----------------------------------------------------------------------------
// lpom_pkg
// shared types and constants of the low pulse occupancy meter
// ----------------------------------------------------------------------------
package lpom_pkg;
  localparam int RingDepth = 32;
  localparam int TickWidth = 16;
  localparam int PtrWidth = $clog2(RingDepth);
  localparam int SumWidth = TickWidth + PtrWidth;
  localparam int QueueDepth = 2;

  localparam logic [2:0] CFG_WINDOW = 3'd0;
  localparam logic [2:0] CFG_OCC = 3'd1;
  localparam logic [2:0] CFG_MPT = 3'd2;
  localparam logic [2:0] CFG_HIGH = 3'd3;
  localparam logic [2:0] CFG_LOW = 3'd4;
  localparam logic [2:0] CFG_EN = 3'd5;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CONV = 1'b1;

  typedef struct packed {
    logic       conv;
    logic       pin;
    logic [3:0] mask;
  } cmd_t;

  typedef struct packed {
    logic [15:0] window_ticks;
    logic [23:0] occ_scale;
    logic [23:0] mpt_scale;
    logic [31:0] high_th;
    logic [31:0] low_th;
    logic [7:0]  alarm_en;
  } cfg_t;
endpackage

[src/lpom_ram.sv]
// ----------------------------------------------------------------------------
// lpom_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lpom_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[src/lpom_front.sv]
// ----------------------------------------------------------------------------
// lpom_front
// input beat acceptance and two entry command queue
// ----------------------------------------------------------------------------
`include "low_pulse_occupancy_meter_assert.svh"

module lpom_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpom_pkg::cmd_t     in_cmd,
  output logic               q_valid,
  input  logic               q_pop,
  output lpom_pkg::cmd_t     q_cmd
);
  lpom_pkg::cmd_t mem_r [lpom_pkg::QueueDepth];
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rd_r];

  always_comb begin
    rd_nxt = rd_r ^ q_pop;
    wr_nxt = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= in_cmd;
    end
  end

  `LPOM_ASSERT_IMP(a_no_pop_empty, q_pop, cnt_r != 2'd0)
  `LPOM_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r != 2'd3)
  `LPOM_ASSERT_NXT(a_push_only, push && !q_pop, cnt_r != 2'd0)
endmodule

[src/lpom_back.sv]
// ----------------------------------------------------------------------------
// lpom_back
// pulse tracking, window ring, conversion pipeline and output register
// ----------------------------------------------------------------------------
`include "low_pulse_occupancy_meter_assert.svh"

module lpom_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lpom_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  lpom_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_pulse_count_sum,
  output logic [15:0]        out_occupancy_value,
  output logic [15:0]        out_longest_pulse_us,
  output logic [15:0]        out_shortest_pulse_us,
  output logic [3:0]         out_alarm_high_flags,
  output logic [3:0]         out_alarm_low_flags,
  output logic               out_alarm_any
);
  localparam int TW = lpom_pkg::TickWidth;
  localparam int PW = lpom_pkg::PtrWidth;
  localparam int SW = lpom_pkg::SumWidth;
  localparam int RingDepthW = lpom_pkg::RingDepth;
  localparam logic [TW-1:0] TickMax = {TW{1'b1}};

  logic [TW-1:0] pos_r, pos_nxt, start_r, start_nxt, low_r, low_nxt;
  logic [TW-1:0] cnt_r, cnt_nxt, short_r, short_nxt, long_r, long_nxt;
  logic          prev_r, prev_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [SW-1:0] slow_r, slow_nxt, scnt_r, scnt_nxt;
  logic [RingDepthW-1:0] vld_r, vld_nxt;

  // close pipeline: read old ring entry, then adjust sums
  logic          cl_r;
  logic [PW-1:0] cl_ptr_r;
  logic [TW-1:0] cl_low_r, cl_cnt_r;
  logic          cl_old_vld_r;
  logic [TW-1:0] old_low, old_cnt;

  // convert pipeline
  logic          cv_r;
  logic [3:0]    cv_mask_r;
  logic [SW-1:0] cv_scnt_r, cv_slow_r;
  logic [TW-1:0] cv_long_r, cv_short_r;
  logic          cv2_r;
  logic [3:0]    cv2_mask_r;
  logic [SW+23:0] prod_b_r;
  logic [TW+23:0] prod_c_r, prod_d_r;
  logic [SW-1:0] cv2_scnt_r;

  logic [15:0] ch_r [4];
  logic [15:0] ch_nxt [4];
  logic [15:0] ch_new [4];
  logic        ovalid_r;
  logic [3:0]  hi_r, lo_r, hi_nxt, lo_nxt;
  logic        out_free, en1, en2;
  logic        adv, is_tick, is_conv, rise, fall, close;
  logic [TW:0] next_pos, dsum;
  logic [TW-1:0] d, old_low_sel, old_cnt_sel;
  logic [SW-1:0] slow_fix, scnt_fix;
  logic [SW+23:0] bsh;
  logic [TW+23:0] csh, dsh;

  // a converter stage advances when it is empty or the next stage frees up
  assign out_free = !ovalid_r || out_ready;
  assign en2 = !cv2_r || out_free;
  assign en1 = !cv_r || en2;
  assign q_pop = q_valid && ((q_cmd.conv != lpom_pkg::FUNC_CONV) || en1);
  assign adv = q_pop;
  assign is_tick = adv && (q_cmd.conv == lpom_pkg::FUNC_TICK);
  assign is_conv = adv && (q_cmd.conv == lpom_pkg::FUNC_CONV);
  assign rise = !prev_r && q_cmd.pin;
  assign fall = prev_r && !q_cmd.pin;
  assign d = pos_r - start_r;
  assign next_pos = {1'b0, pos_r} + 1'b1;
  assign close = (next_pos >= {1'b0, cfg.window_ticks}) || next_pos[TW];
  assign dsum = {1'b0, low_r} + {1'b0, d};

  lpom_ram #(.Width(TW), .Depth(lpom_pkg::RingDepth)) u_ram_low (
    .clk(clk), .we(cl_r), .waddr(cl_ptr_r), .wdata(cl_low_r),
    .raddr(ptr_r), .rdata(old_low));
  lpom_ram #(.Width(TW), .Depth(lpom_pkg::RingDepth)) u_ram_cnt (
    .clk(clk), .we(cl_r), .waddr(cl_ptr_r), .wdata(cl_cnt_r),
    .raddr(ptr_r), .rdata(old_cnt));

  // a close is registered in cl_r before it reaches the sum registers; forward
  always_comb begin
    old_low_sel = cl_old_vld_r ? old_low : '0;
    old_cnt_sel = cl_old_vld_r ? old_cnt : '0;
    slow_fix = slow_r;
    scnt_fix = scnt_r;
    if (cl_r) begin
      slow_fix = slow_r - SW'(old_low_sel) + SW'(cl_low_r);
      scnt_fix = scnt_r - SW'(old_cnt_sel) + SW'(cl_cnt_r);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    start_nxt = start_r;
    low_nxt = low_r;
    cnt_nxt = cnt_r;
    short_nxt = short_r;
    long_nxt = long_r;
    prev_nxt = prev_r;
    ptr_nxt = ptr_r;
    vld_nxt = vld_r;
    slow_nxt = slow_fix;
    scnt_nxt = scnt_fix;
    if (is_tick) begin
      if (fall) begin
        start_nxt = pos_r;
      end else if (rise) begin
        low_nxt = dsum[TW] ? TickMax : dsum[TW-1:0];
        if (cnt_r != TickMax) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (short_r == '0 || d < short_r) begin
          short_nxt = d;
        end
        if (d > long_r) begin
          long_nxt = d;
        end
      end
      prev_nxt = q_cmd.pin;
      if (close) begin
        vld_nxt[ptr_r] = 1'b1;
        ptr_nxt = (ptr_r == PW'(lpom_pkg::RingDepth - 1)) ? '0 : ptr_r + 1'b1;
        pos_nxt = '0;
        start_nxt = '0;
        low_nxt = '0;
        cnt_nxt = '0;
      end else begin
        pos_nxt = next_pos[TW-1:0];
      end
    end
    if (is_conv) begin
      if (q_cmd.mask[2]) begin
        long_nxt = '0;
      end
      if (q_cmd.mask[3]) begin
        short_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      start_r <= '0;
      low_r <= '0;
      cnt_r <= '0;
      short_r <= '0;
      long_r <= '0;
      prev_r <= 1'b1;
      ptr_r <= '0;
      vld_r <= '0;
      slow_r <= '0;
      scnt_r <= '0;
      cl_r <= 1'b0;
      cv_r <= 1'b0;
      cv2_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      start_r <= start_nxt;
      low_r <= low_nxt;
      cnt_r <= cnt_nxt;
      short_r <= short_nxt;
      long_r <= long_nxt;
      prev_r <= prev_nxt;
      ptr_r <= ptr_nxt;
      vld_r <= vld_nxt;
      slow_r <= slow_nxt;
      scnt_r <= scnt_nxt;
      cl_r <= is_tick && close;
      if (en1) begin
        cv_r <= is_conv;
      end
      if (en2) begin
        cv2_r <= cv_r;
      end
    end
    cl_ptr_r <= ptr_r;
    cl_low_r <= rise ? (dsum[TW] ? TickMax : dsum[TW-1:0]) : low_r;
    cl_cnt_r <= (rise && cnt_r != TickMax) ? cnt_r + 1'b1 : cnt_r;
    cl_old_vld_r <= vld_r[ptr_r];
    if (en1) begin
      cv_mask_r <= q_cmd.mask;
      cv_scnt_r <= scnt_fix;
      cv_slow_r <= slow_fix;
      cv_long_r <= long_r;
      cv_short_r <= short_r;
    end
    if (en2) begin
      cv2_mask_r <= cv_mask_r;
      cv2_scnt_r <= cv_scnt_r;
      prod_b_r <= cv_slow_r * (SW+24)'(cfg.occ_scale);
      prod_c_r <= cv_long_r * (TW+24)'(cfg.mpt_scale);
      prod_d_r <= cv_short_r * (TW+24)'(cfg.mpt_scale);
    end
  end

  always_comb begin
    bsh = prod_b_r >> 24;
    csh = prod_c_r >> 16;
    dsh = prod_d_r >> 16;
    ch_new[0] = (cv2_scnt_r > SW'(16'hffff)) ? 16'hffff : cv2_scnt_r[15:0];
    ch_new[1] = (bsh > (SW+24)'(16'hffff)) ? 16'hffff : bsh[15:0];
    ch_new[2] = (csh > (TW+24)'(16'hffff)) ? 16'hffff : csh[15:0];
    ch_new[3] = (dsh > (TW+24)'(16'hffff)) ? 16'hffff : dsh[15:0];
    hi_nxt = '0;
    lo_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      ch_nxt[i] = cv2_mask_r[i] ? ch_new[i] : ch_r[i];
      if (cv2_mask_r[i]) begin
        hi_nxt[i] = cfg.alarm_en[2*i+1] && (ch_new[i][15:8] > cfg.high_th[8*i +: 8]);
        lo_nxt[i] = cfg.alarm_en[2*i] && (ch_new[i][15:8] < cfg.low_th[8*i +: 8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        ch_r[i] <= '0;
      end
    end else begin
      if (cv2_r && out_free) begin
        ovalid_r <= 1'b1;
        for (int i = 0; i < 4; i++) begin
          ch_r[i] <= ch_nxt[i];
        end
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
    if (cv2_r && out_free) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_pulse_count_sum = ch_r[0];
  assign out_occupancy_value = ch_r[1];
  assign out_longest_pulse_us = ch_r[2];
  assign out_shortest_pulse_us = ch_r[3];
  assign out_alarm_high_flags = hi_r;
  assign out_alarm_low_flags = lo_r;
  assign out_alarm_any = |{hi_r, lo_r};

  `LPOM_ASSERT_NXT(a_out_hold, ovalid_r && !out_ready, ovalid_r)
  `LPOM_ASSERT_NXT(a_stage_hold, cv2_r && ovalid_r && !out_ready, cv2_r)
  `LPOM_ASSERT_NXT(a_close_write, is_tick && close, cl_r)
endmodule

[src/low_pulse_occupancy_meter.sv]
// a convert beat's result passes through the queue, the converter stages cv and
// cv2 and the output register before out_valid rises
// throughput: one beat per cycle while the output is not held; a held result
// stalls two converts in the converter, then the queue fills and the input stalls
// reset: synchronous active low clears counters, sums, ring valid bits and
// channel values; configuration returns to its defaults
// ----------------------------------------------------------------------------
// low_pulse_occupancy_meter
// low pulse occupancy meter with window ring and four channel converter
// ----------------------------------------------------------------------------
module low_pulse_occupancy_meter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic        in_pin_level,
  input  logic [3:0]  in_channel_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pulse_count_sum,
  output logic [15:0] out_occupancy_value,
  output logic [15:0] out_longest_pulse_us,
  output logic [15:0] out_shortest_pulse_us,
  output logic [3:0]  out_alarm_high_flags,
  output logic [3:0]  out_alarm_low_flags,
  output logic        out_alarm_any
);
  lpom_pkg::cfg_t cfg_r;
  lpom_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks <= 16'd31550;
      cfg_r.occ_scale <= 24'd213540;
      cfg_r.mpt_scale <= 24'd2077248;
      cfg_r.high_th <= 32'hffffffff;
      cfg_r.low_th <= '0;
      cfg_r.alarm_en <= 8'hff;
    end else if (cfg_we) begin
      case (cfg_index)
        lpom_pkg::CFG_WINDOW: cfg_r.window_ticks <= cfg_data[15:0];
        lpom_pkg::CFG_OCC: cfg_r.occ_scale <= cfg_data[23:0];
        lpom_pkg::CFG_MPT: cfg_r.mpt_scale <= cfg_data[23:0];
        lpom_pkg::CFG_HIGH: cfg_r.high_th <= cfg_data;
        lpom_pkg::CFG_LOW: cfg_r.low_th <= cfg_data;
        lpom_pkg::CFG_EN: cfg_r.alarm_en <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_cmd = '{conv: in_func, pin: in_pin_level, mask: in_channel_mask};

  lpom_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

  lpom_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
    .out_pulse_count_sum(out_pulse_count_sum),
    .out_occupancy_value(out_occupancy_value),
    .out_longest_pulse_us(out_longest_pulse_us),
    .out_shortest_pulse_us(out_shortest_pulse_us),
    .out_alarm_high_flags(out_alarm_high_flags),
    .out_alarm_low_flags(out_alarm_low_flags),
    .out_alarm_any(out_alarm_any));
endmodule

[bench/tb_low_pulse_occupancy_meter.sv]
// ----------------------------------------------------------------------------
// tb_low_pulse_occupancy_meter
// self-checking bench: tick and convert beats driven with random idling, each
// convert result compared against a behavioral model of windows, ring and
// channel converter, under several register settings
// ----------------------------------------------------------------------------
module tb_low_pulse_occupancy_meter;

  typedef struct packed {
    logic [15:0] a, b, c, d;
    logic [3:0]  hi, lo;
    logic        any;
  } reading_t;

  typedef struct {
    logic       func;
    logic       pin;
    logic [3:0] mask;
    logic       fixed;
    reading_t   want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = lpom_pkg::CFG_WINDOW;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = lpom_pkg::FUNC_TICK;
  logic        in_pin_level = 1'b1;
  logic [3:0]  in_channel_mask = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pulse_count_sum, out_occupancy_value;
  logic [15:0] out_longest_pulse_us, out_shortest_pulse_us;
  logic [3:0]  out_alarm_high_flags, out_alarm_low_flags;
  logic        out_alarm_any;

  low_pulse_occupancy_meter dut (.*);

  always #1 clk = ~clk;

  // model state
  logic [15:0] m_win, m_pos, m_start, m_low, m_cnt, m_short, m_long;
  logic [23:0] m_occ, m_mpt;
  logic [31:0] m_hth, m_lth;
  logic [7:0]  m_en;
  logic        m_prev;
  logic [15:0] m_ring_low [lpom_pkg::RingDepth];
  logic [15:0] m_ring_cnt [lpom_pkg::RingDepth];
  logic [4:0]  m_ptr;
  logic [20:0] m_sum_low, m_sum_cnt;
  logic [15:0] m_chan [4];

  reading_t readings_due[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_long = 1'b0;

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic logic [15:0] sat16(input logic [63:0] v);
    return (v > 64'd65535) ? 16'hffff : v[15:0];
  endfunction

  task automatic model_reset();
    m_win = 16'd31550; m_occ = 24'd213540; m_mpt = 24'd2077248;
    m_hth = '1; m_lth = '0; m_en = 8'hff;
    m_pos = '0; m_start = '0; m_low = '0; m_cnt = '0; m_short = '0; m_long = '0;
    m_prev = 1'b1; m_ptr = '0; m_sum_low = '0; m_sum_cnt = '0;
    for (int i = 0; i < lpom_pkg::RingDepth; i++) begin
      m_ring_low[i] = '0; m_ring_cnt[i] = '0;
    end
    for (int i = 0; i < 4; i++) m_chan[i] = '0;
  endtask

  task automatic model_config(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      lpom_pkg::CFG_WINDOW: m_win = v[15:0];
      lpom_pkg::CFG_OCC: m_occ = v[23:0];
      lpom_pkg::CFG_MPT: m_mpt = v[23:0];
      lpom_pkg::CFG_HIGH: m_hth = v;
      lpom_pkg::CFG_LOW: m_lth = v;
      lpom_pkg::CFG_EN: m_en = v[7:0];
      default: ;
    endcase
  endtask

  task automatic advance_window(input logic pin);
    logic [15:0] len;
    logic [16:0] acc;
    logic [16:0] nxt;
    if (m_prev && !pin) begin
      m_start = m_pos;
    end else if (!m_prev && pin) begin
      len = m_pos - m_start;
      acc = m_low + len;
      m_low = acc[16] ? 16'hffff : acc[15:0];
      if (m_cnt != 16'hffff) m_cnt++;
      if (m_short == 0) m_short = len;
      if (len > m_long) m_long = len;
      if (len < m_short) m_short = len;
    end
    m_prev = pin;
    nxt = m_pos + 17'd1;
    if (nxt >= m_win || nxt > 17'hffff) begin
      m_sum_low = m_sum_low - m_ring_low[m_ptr] + m_low;
      m_sum_cnt = m_sum_cnt - m_ring_cnt[m_ptr] + m_cnt;
      m_ring_low[m_ptr] = m_low;
      m_ring_cnt[m_ptr] = m_cnt;
      m_ptr++;
      m_pos = '0; m_start = '0; m_low = '0; m_cnt = '0;
    end else begin
      m_pos = nxt[15:0];
    end
  endtask

  function automatic reading_t convert_channels(input logic [3:0] mask);
    reading_t r;
    logic [7:0] hb, hl, ll;
    r.hi = '0; r.lo = '0;
    if (mask[0]) m_chan[0] = sat16(64'(m_sum_cnt));
    if (mask[1]) m_chan[1] = sat16((64'(m_sum_low) * 64'(m_occ)) >> 24);
    if (mask[2]) begin
      m_chan[2] = sat16((64'(m_long) * 64'(m_mpt)) >> 16);
      m_long = '0;
    end
    if (mask[3]) begin
      m_chan[3] = sat16((64'(m_short) * 64'(m_mpt)) >> 16);
      m_short = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        hb = m_chan[i][15:8];
        hl = m_hth[8*i +: 8];
        ll = m_lth[8*i +: 8];
        if (m_en[2*i+1] && hb > hl) r.hi[i] = 1'b1;
        if (m_en[2*i] && hb < ll) r.lo[i] = 1'b1;
      end
    end
    r.a = m_chan[0]; r.b = m_chan[1]; r.c = m_chan[2]; r.d = m_chan[3];
    r.any = |{r.hi, r.lo};
    return r;
  endfunction

  task automatic send_beat(input logic func, input logic pin, input logic [3:0] mask,
                           input bit idle);
    int gap;
    if (idle && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_pin_level <= pin;
    in_channel_mask <= mask;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (func == lpom_pkg::FUNC_TICK) advance_window(pin);
    else readings_due.push_back(convert_channels(mask));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_config(idx, v);
  endtask

  // receiver: random stall bursts plus one long hold-off
  initial begin
    int n;
    n = 0;
    forever begin
      @(negedge clk);
      if (n > 0) n--;
      else if (!quiet && $urandom_range(0, 9) == 0) n = $urandom_range(1, 7);
      out_ready <= !(hold_long || n > 0);
    end
  end

  always @(posedge clk) begin
    reading_t w;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        report("result with nothing expected");
      end else begin
        w = readings_due.pop_front();
        if (out_pulse_count_sum !== w.a)
          report($sformatf("channel a %0d want %0d", out_pulse_count_sum, w.a));
        if (out_occupancy_value !== w.b)
          report($sformatf("channel b %0d want %0d", out_occupancy_value, w.b));
        if (out_longest_pulse_us !== w.c)
          report($sformatf("channel c %0d want %0d", out_longest_pulse_us, w.c));
        if (out_shortest_pulse_us !== w.d)
          report($sformatf("channel d %0d want %0d", out_shortest_pulse_us, w.d));
        if (out_alarm_high_flags !== w.hi)
          report($sformatf("high flags %h want %h", out_alarm_high_flags, w.hi));
        if (out_alarm_low_flags !== w.lo)
          report($sformatf("low flags %h want %h", out_alarm_low_flags, w.lo));
        if (out_alarm_any !== w.any)
          report($sformatf("any %b want %b", out_alarm_any, w.any));
      end
    end
    if (cycles > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  row_t plan[$];

  task automatic add_row(input logic f, input logic p, input logic [3:0] m);
    row_t r;
    r.func = f; r.pin = p; r.mask = m; r.fixed = 1'b0;
    plan.push_back(r);
  endtask

  initial begin
    row_t r;
    reading_t zero_r;
    model_reset();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // after reset all channels read zero with no alarm
    zero_r = '{a: 0, b: 0, c: 0, d: 0, hi: 0, lo: 0, any: 0};
    r.func = lpom_pkg::FUNC_CONV; r.pin = 1'b0; r.mask = 4'hf; r.fixed = 1'b1;
    r.want = zero_r;
    plan.push_back(r);
    r.mask = 4'h0; r.pin = 1'b1;
    plan.push_back(r);
    foreach (plan[i]) begin
      send_beat(plan[i].func, plan[i].pin, plan[i].mask, 1'b0);
      if (plan[i].fixed && readings_due[$] != plan[i].want)
        report("directed row disagrees with typed result");
    end
    drain();
    plan.delete();

    // short windows: boundary-crossing and zero-length pulses, alarms
    write_reg(lpom_pkg::CFG_WINDOW, 32'd3);
    write_reg(lpom_pkg::CFG_OCC, 32'hffffff);
    write_reg(lpom_pkg::CFG_MPT, 32'hffffff);
    write_reg(lpom_pkg::CFG_HIGH, 32'h00000000);
    write_reg(lpom_pkg::CFG_LOW, 32'hffffffff);
    write_reg(lpom_pkg::CFG_EN, 32'h000000ff);
    add_row(lpom_pkg::FUNC_TICK, 1'b0, 4'h0);
    add_row(lpom_pkg::FUNC_TICK, 1'b0, 4'hf);
    add_row(lpom_pkg::FUNC_TICK, 1'b0, 4'h0);
    add_row(lpom_pkg::FUNC_TICK, 1'b1, 4'h0);
    add_row(lpom_pkg::FUNC_TICK, 1'b0, 4'h0);
    add_row(lpom_pkg::FUNC_TICK, 1'b0, 4'h0);
    add_row(lpom_pkg::FUNC_TICK, 1'b1, 4'h0);
    add_row(lpom_pkg::FUNC_CONV, 1'b1, 4'h1);
    add_row(lpom_pkg::FUNC_CONV, 1'b0, 4'h2);
    add_row(lpom_pkg::FUNC_CONV, 1'b1, 4'h4);
    add_row(lpom_pkg::FUNC_CONV, 1'b0, 4'h8);
    add_row(lpom_pkg::FUNC_CONV, 1'b0, 4'hf);
    foreach (plan[i]) send_beat(plan[i].func, plan[i].pin, plan[i].mask, 1'b1);
    drain();

    // window of zero and one: every tick closes
    write_reg(lpom_pkg::CFG_WINDOW, 32'd0);
    repeat (6) send_beat(lpom_pkg::FUNC_TICK, 1'($urandom_range(0, 1)), 4'h0, 1'b1);
    send_beat(lpom_pkg::FUNC_CONV, 1'b0, 4'hf, 1'b1);
    drain();
    write_reg(lpom_pkg::CFG_WINDOW, 32'd1);
    repeat (6) send_beat(lpom_pkg::FUNC_TICK, 1'($urandom_range(0, 1)), 4'h0, 1'b1);
    send_beat(lpom_pkg::FUNC_CONV, 1'b1, 4'hf, 1'b1);
    drain();

    // long hold-off on the receiver while converts keep coming
    hold_long = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk);
        hold_long = 1'b0;
      end
      repeat (12) send_beat(lpom_pkg::FUNC_CONV, 1'b0, 4'($urandom_range(0, 15)), 1'b0);
    join
    drain();

    // random phases under several register settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(lpom_pkg::CFG_WINDOW,
                (ph == 4) ? 32'd65535 : 32'($urandom_range(2, 40)));
      write_reg(lpom_pkg::CFG_OCC, (ph == 0) ? 32'd0 : {8'h0, 24'($urandom)});
      write_reg(lpom_pkg::CFG_MPT, (ph == 0) ? 32'd0 : {8'h0, 24'($urandom)});
      write_reg(lpom_pkg::CFG_HIGH, $urandom);
      write_reg(lpom_pkg::CFG_LOW, $urandom);
      write_reg(lpom_pkg::CFG_EN, 32'($urandom_range(0, 255)));
      if (ph == 4) quiet = 1'b1;
      for (int k = 0; k < 140; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(lpom_pkg::FUNC_CONV, 1'($urandom_range(0, 1)),
                    4'($urandom_range(0, 15)), 1'b1);
        else
          send_beat(lpom_pkg::FUNC_TICK, ($urandom_range(0, 2) != 0),
                    4'($urandom_range(0, 15)), 1'b1);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
